>>> rtl/core/avsfrq_pkg.sv
// package for the frame release queue: transaction types, command, action
// and register codes, and the cell control struct
// no dependencies
`default_nettype none

package avsfrq_pkg;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 32;

	// command codes
	localparam logic [2:0] CMD_PUSH   = 3'd0;
	localparam logic [2:0] CMD_TICK   = 3'd1;
	localparam logic [2:0] CMD_START  = 3'd2;
	localparam logic [2:0] CMD_STOP   = 3'd3;
	localparam logic [2:0] CMD_PAUSE  = 3'd4;
	localparam logic [2:0] CMD_RESUME = 3'd5;
	localparam logic [2:0] CMD_FLUSH  = 3'd6;

	// action codes
	localparam logic [1:0] ACT_RENDER   = 2'd0;
	localparam logic [1:0] ACT_LATE     = 2'd1;
	localparam logic [1:0] ACT_OVERFLOW = 2'd2;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_LATE_LIMIT   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_EARLY_WINDOW = 2'd1;

	localparam logic [CFG_DATA_W-1:0] LATE_LIMIT_RESET   = 32'd40000;
	localparam logic [CFG_DATA_W-1:0] EARLY_WINDOW_RESET = 32'd5000;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [63:0] frame_pts;
		logic [15:0]        frame_handle;
		logic signed [63:0] clock_now;
	} cmd_t;

	typedef struct packed {
		logic [15:0] out_handle;
		logic [1:0]  action;
	} evt_t;

	// one queued frame
	typedef struct packed {
		logic signed [63:0] pts;
		logic [15:0]        handle;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/avsfrq_cell.sv
// one slot of the shifting frame queue
// depends on avsfrq_pkg
`default_nettype none

module avsfrq_cell (
	input  wire logic                clk,
	input  wire avsfrq_pkg::cell_ctrl_t ctrl,
	input  wire avsfrq_pkg::entry_t  load_data,
	input  wire avsfrq_pkg::entry_t  next_data,
	output avsfrq_pkg::entry_t       data
);
	import avsfrq_pkg::*;

	entry_t data_q;

	// load wins over shift: the new frame lands after the queue moved
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= load_data;
		end else if (ctrl.shift) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

>>> rtl/core/av_sync_frame_release_queue.sv
// top level of the frame release queue: command decode, run flags, late and
// early compare, result register and the row of queue cells
// depends on avsfrq_pkg and avsfrq_cell
`default_nettype none

// usage
//   cmd channel (cmd_valid/cmd_stall/cmd_data) carries push, tick, start,
//   stop, pause, resume and flush commands. a transaction is taken at a
//   rising edge with cmd_valid high and cmd_stall low.
//   evt channel (evt_valid/evt_stall/evt_data) returns at most one result
//   per command: a released frame, a late drop or an overflow drop.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the late
//   limit (index 0) and early window (index 1); cfg_ready is always high.
// timing
//   every command is handled in the cycle it is taken, by the 65-bit delay
//   subtract and compare on the head cell; commands go back to back while
//   cmd_stall is low. a result shows on evt in the cycle after its command.
//   queue storage is a row of QUEUE_DEPTH cells; a pop shifts every cell
//   one place toward the head, a push loads the cell after the last frame.
// reset
//   stopped, not paused, queue empty, registers at their defaults.
// stall
//   the result register holds while evt_stall is high; cmd_stall is raised
//   only while a held result is waiting, so commands keep flowing otherwise.
module av_sync_frame_release_queue #(
	parameter int unsigned QUEUE_DEPTH = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cmd_valid,
	output logic                                     cmd_stall,
	input  wire avsfrq_pkg::cmd_t                    cmd_data,
	output logic                                     evt_valid,
	input  wire logic                                evt_stall,
	output avsfrq_pkg::evt_t                         evt_data,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [avsfrq_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [avsfrq_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import avsfrq_pkg::*;

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

	// control state
	logic [CNT_W-1:0]      count_q;
	logic                  running_q;
	logic                  paused_q;
	logic [CFG_DATA_W-1:0] late_limit_q;
	logic [CFG_DATA_W-1:0] early_window_q;
	logic                  evt_valid_q;
	evt_t                  evt_data_q;

	// cell row
	entry_t     cell_data [QUEUE_DEPTH];
	cell_ctrl_t cell_ctrl [QUEUE_DEPTH];
	entry_t     new_entry;

	logic             accept;
	logic             push_ok;
	logic             tick_ok;
	logic             pop_ovf;
	logic             pop_late;
	logic             pop_rend;
	logic             pop;
	logic             clear;
	logic             full;
	logic [CNT_W-1:0] slot;
	logic [CNT_W-1:0] count_d;

	// delay compare; saturating the delay never changes the outcome since
	// both thresholds lie well inside the 64-bit range, so compare exactly
	logic signed [64:0] delay;
	logic signed [65:0] late_sum;
	logic               is_late;
	logic               is_early;

	assign cfg_ready = 1'b1;

	// hold off new commands only while a result is stuck at the output
	assign cmd_stall = evt_valid_q && evt_stall;
	assign accept    = cmd_valid && !cmd_stall;

	assign full = (count_q == FULL_COUNT);

	assign delay    = {cell_data[0].pts[63], cell_data[0].pts}
	                - {cmd_data.clock_now[63], cmd_data.clock_now};
	assign late_sum = {delay[64], delay} + {34'd0, late_limit_q};
	assign is_late  = late_sum[65];
	assign is_early = ($signed({delay[64], delay}) < $signed({34'd0, early_window_q}));

	assign push_ok  = accept && (cmd_data.command == CMD_PUSH) && running_q;
	assign tick_ok  = accept && (cmd_data.command == CMD_TICK) && running_q
	                  && !paused_q && (count_q != '0);
	assign pop_ovf  = push_ok && full;
	assign pop_late = tick_ok && is_late;
	assign pop_rend = tick_ok && !is_late && is_early;
	assign pop      = pop_ovf || pop_late || pop_rend;
	assign clear    = accept && ((cmd_data.command == CMD_STOP)
	                  || (cmd_data.command == CMD_FLUSH));

	// slot the new frame goes to, after any pop has shifted the row
	assign slot = count_q - CNT_W'(pop);

	always_comb begin
		if (clear) begin
			count_d = '0;
		end else begin
			count_d = count_q - CNT_W'(pop) + CNT_W'(push_ok);
		end
	end

	assign new_entry.pts    = cmd_data.frame_pts;
	assign new_entry.handle = cmd_data.frame_handle;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t next_data;

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign next_data = new_entry;
		end else begin : g_body
			assign next_data = cell_data[i+1];
		end

		assign cell_ctrl[i].shift = pop;
		assign cell_ctrl[i].load  = push_ok && (slot == CNT_W'(i));

		avsfrq_cell u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl[i]),
			.load_data (new_entry),
			.next_data (next_data),
			.data      (cell_data[i])
		);
	end

	// queue count and run flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			running_q <= 1'b0;
			paused_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				case (cmd_data.command)
					CMD_START: begin
						if (!running_q) begin
							running_q <= 1'b1;
							paused_q  <= 1'b0;
						end
					end
					CMD_STOP: begin
						running_q <= 1'b0;
						paused_q  <= 1'b0;
					end
					CMD_PAUSE: begin
						if (running_q) begin
							paused_q <= 1'b1;
						end
					end
					CMD_RESUME: begin
						if (running_q) begin
							paused_q <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			late_limit_q   <= LATE_LIMIT_RESET;
			early_window_q <= EARLY_WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LATE_LIMIT:   late_limit_q   <= cfg_data;
				REG_EARLY_WINDOW: early_window_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (pop) begin
			evt_valid_q <= 1'b1;
		end else if (!evt_stall) begin
			evt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			evt_data_q.out_handle <= cell_data[0].handle;
			if (pop_ovf) begin
				evt_data_q.action <= ACT_OVERFLOW;
			end else if (pop_late) begin
				evt_data_q.action <= ACT_LATE;
			end else begin
				evt_data_q.action <= ACT_RENDER;
			end
		end
	end

	assign evt_valid = evt_valid_q;
	assign evt_data  = evt_data_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("queue count above depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("pop from an empty queue");

	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd_data.command == CMD_STOP)) |=> (count_q == '0) && !running_q)
		else $error("stop left frames or run flag");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push_ok && !full) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("push into a non-full queue did not add a frame");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid_q && evt_stall) |-> !pop)
		else $error("new result while a stalled one is waiting");

endmodule

`default_nettype wire

>>> sim/tb_av_sync_frame_release_queue.sv
// self-checking testbench for av_sync_frame_release_queue: a table of directed
// commands, then random phases under several limit settings, checked against
// a cycle-free model of the frame queue; depends on avsfrq_pkg and the rtl
module tb_av_sync_frame_release_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import avsfrq_pkg::*;

	localparam int DEPTH          = 8;
	localparam int PHASES         = 12;
	localparam int PHASE_ITEMS    = 135;
	localparam int IDLE_LIMIT     = 2000;
	localparam int SETTLE_CYCLES  = 6;

	// command code that the block must ignore
	localparam logic [2:0] CMD_UNUSED = 3'd7;
	// register index that decodes to nothing
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

	localparam logic signed [63:0] PTS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] PTS_MIN = 64'sh8000_0000_0000_0000;

	// how a table row is checked
	localparam int ROW_QUIET = 0;  // no result, written in the table
	localparam int ROW_EVENT = 1;  // result written in the table
	localparam int ROW_MODEL = 2;  // result from the queue model

	typedef struct {
		cmd_t cmd;
		int   kind;
		evt_t ev;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	cmd_t        cmd_data = '0;
	logic        evt_valid;
	logic        evt_stall = 1'b0;
	evt_t        evt_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// model of the queue, updated at each accepted command or register write
	logic signed [63:0] mirror_pts [DEPTH];
	logic [15:0]        mirror_hdl [DEPTH];
	int                 mirror_head = 0;
	int                 mirror_fill = 0;
	bit                 is_running = 1'b0;
	bit                 is_paused = 1'b0;
	logic [31:0]        late_us = LATE_LIMIT_RESET;
	logic [31:0]        early_us = EARLY_WINDOW_RESET;

	// releases and drops still owed by the block, oldest first
	evt_t pending_releases [$];

	int  fault_count = 0;
	bit  steady = 1'b0;       // no gaps on either side while set
	int  stall_run = 0;
	int  idle_run = 0;
	longint media_us;
	plan_row_t plan [$];

	av_sync_frame_release_queue #(
		.QUEUE_DEPTH(DEPTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_data  (cmd_data),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt_data  (evt_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void note_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%s", msg);
	endfunction

	// mostly back to back, short gaps often, a long one now and then
	function automatic int gap_len();
		int p;
		if (steady)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		if (p < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// frame delay against the clock, clamped to the signed 64-bit range
	function automatic longint sat_delay(input logic signed [63:0] pts,
			input logic signed [63:0] now);
		logic [64:0] wide;
		wide = {pts[63], pts} - {now[63], now};
		if (wide[64] != wide[63])
			return wide[64] ? PTS_MIN : PTS_MAX;
		return longint'(wide[63:0]);
	endfunction

	function automatic logic [15:0] take_head();
		logic [15:0] h;
		h = mirror_hdl[mirror_head];
		mirror_head = (mirror_head + 1) % DEPTH;
		mirror_fill = mirror_fill - 1;
		return h;
	endfunction

	// one command applied to the queue model
	task automatic frame_queue_step(input cmd_t c, output bit fired, output evt_t ev);
		longint delay;
		int slot;
		fired = 1'b0;
		ev = '0;
		case (c.command)
			CMD_PUSH: begin
				if (is_running) begin
					// full queue: oldest frame goes out first
					if (mirror_fill == DEPTH) begin
						ev.out_handle = take_head();
						ev.action = ACT_OVERFLOW;
						fired = 1'b1;
					end
					slot = (mirror_head + mirror_fill) % DEPTH;
					mirror_pts[slot] = c.frame_pts;
					mirror_hdl[slot] = c.frame_handle;
					mirror_fill = mirror_fill + 1;
				end
			end
			CMD_TICK: begin
				if (is_running && !is_paused && mirror_fill != 0) begin
					delay = sat_delay(mirror_pts[mirror_head], c.clock_now);
					if (delay < -longint'({32'd0, late_us})) begin
						ev.out_handle = take_head();
						ev.action = ACT_LATE;
						fired = 1'b1;
					end else if (delay < longint'({32'd0, early_us})) begin
						ev.out_handle = take_head();
						ev.action = ACT_RENDER;
						fired = 1'b1;
					end
				end
			end
			CMD_START: begin
				if (!is_running) begin
					is_running = 1'b1;
					is_paused = 1'b0;
				end
			end
			CMD_STOP: begin
				is_running = 1'b0;
				is_paused = 1'b0;
				mirror_head = 0;
				mirror_fill = 0;
			end
			CMD_PAUSE: begin
				if (is_running)
					is_paused = 1'b1;
			end
			CMD_RESUME: begin
				if (is_running)
					is_paused = 1'b0;
			end
			CMD_FLUSH: begin
				mirror_head = 0;
				mirror_fill = 0;
			end
			default: begin
			end
		endcase
	endtask

	function automatic plan_row_t step_row(input logic [2:0] op,
			input logic signed [63:0] pts, input logic [15:0] hdl,
			input logic signed [63:0] now, input int kind,
			input logic [15:0] out_h, input logic [1:0] act);
		plan_row_t r;
		r.cmd.command = op;
		r.cmd.frame_pts = pts;
		r.cmd.frame_handle = hdl;
		r.cmd.clock_now = now;
		r.kind = kind;
		r.ev.out_handle = out_h;
		r.ev.action = act;
		return r;
	endfunction

	// timestamp of a pushed frame: mostly near the media clock, some wild
	function automatic logic signed [63:0] pick_pts();
		int p;
		p = $urandom_range(0, 99);
		if (p < 70) begin
			media_us = media_us + longint'($urandom_range(0, 4000));
			return media_us + longint'($urandom_range(0, 120000)) - 60000;
		end
		if (p < 85)
			return {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return PTS_MAX;
			1: return PTS_MIN;
			2: return 64'sd0;
			default: return -64'sd1;
		endcase
	endfunction

	// clock at a tick: usually aimed at a chosen delay of the head frame,
	// with the late and early edges hit exactly
	function automatic logic signed [63:0] pick_now();
		longint d;
		longint lim_late;
		longint lim_early;
		longint unsigned span;
		logic [64:0] wide;
		logic signed [63:0] hp;
		lim_late = longint'({32'd0, late_us});
		lim_early = longint'({32'd0, early_us});
		if (mirror_fill == 0 || $urandom_range(0, 3) == 0) begin
			if ($urandom_range(0, 1) != 0)
				return {$urandom, $urandom};
			return media_us + longint'($urandom_range(0, 100000)) - 50000;
		end
		hp = mirror_pts[mirror_head];
		case ($urandom_range(0, 5))
			0: d = -lim_late - 1;
			1: d = -lim_late;
			2: d = lim_early - 1;
			3: d = lim_early;
			4: begin
				span = longint'(lim_late + lim_early + 1);
				d = longint'({$urandom, $urandom} % span) - lim_late;
			end
			default: d = {$urandom, $urandom};
		endcase
		wide = {hp[63], hp} - {d[63], d};
		if (wide[64] != wide[63])
			return d;
		return wide[63:0];
	endfunction

	// random command, biased so the queue spends most time running
	function automatic cmd_t make_cmd();
		cmd_t c;
		int p;
		c.command = CMD_TICK;
		c.frame_pts = {$urandom, $urandom};
		c.frame_handle = 16'($urandom);
		c.clock_now = {$urandom, $urandom};
		p = $urandom_range(0, 99);
		if (!is_running && p < 60)
			c.command = CMD_START;
		else if (is_paused && p < 35)
			c.command = CMD_RESUME;
		else begin
			p = $urandom_range(0, 99);
			if (p < 42)
				c.command = CMD_PUSH;
			else if (p < 80)
				c.command = CMD_TICK;
			else if (p < 84)
				c.command = CMD_START;
			else if (p < 88)
				c.command = CMD_PAUSE;
			else if (p < 91)
				c.command = CMD_RESUME;
			else if (p < 94)
				c.command = CMD_STOP;
			else if (p < 97)
				c.command = CMD_FLUSH;
			else
				c.command = CMD_UNUSED;
		end
		if (c.command == CMD_PUSH)
			c.frame_pts = pick_pts();
		if (c.command == CMD_TICK)
			c.clock_now = pick_now();
		return c;
	endfunction

	// hold one command until taken, then book what it should cause
	task automatic send_cmd(input cmd_t c, input int kind, input evt_t typed);
		bit fired;
		evt_t ev;
		cmd_valid <= 1'b1;
		cmd_data <= c;
		do
			@(posedge clk);
		while (cmd_stall);
		frame_queue_step(c, fired, ev);
		if (kind == ROW_QUIET)
			fired = 1'b0;
		else if (kind == ROW_EVENT) begin
			fired = 1'b1;
			ev = typed;
		end
		if (fired)
			pending_releases.push_back(ev);
	endtask

	task automatic idle_cmd(input int n);
		if (n > 0) begin
			cmd_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// sender holds off until every booked result has come back
	task automatic drain_releases();
		cmd_valid <= 1'b0;
		while (pending_releases.size() != 0)
			@(posedge clk);
		// a command with no result may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// leaves cfg_valid high; the caller lowers it after the last write
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_LATE_LIMIT)
			late_us = val;
		else if (idx == REG_EARLY_WINDOW)
			early_us = val;
	endtask

	// result side: compare each transaction with the oldest booked result,
	// and stall at random
	always @(posedge clk) begin
		evt_t want;
		if (arst_n) begin
			if (evt_valid && !evt_stall) begin
				if (pending_releases.size() == 0)
					note_fault($sformatf("unexpected result: handle %h action %0d",
						evt_data.out_handle, evt_data.action));
				else begin
					want = pending_releases.pop_front();
					if (evt_data.out_handle !== want.out_handle ||
							evt_data.action !== want.action)
						note_fault($sformatf(
							"result mismatch: handle %h action %0d, wanted %h action %0d",
							evt_data.out_handle, evt_data.action,
							want.out_handle, want.action));
				end
			end
			if (stall_run > 0) begin
				evt_stall <= 1'b1;
				stall_run <= stall_run - 1;
			end else begin
				evt_stall <= 1'b0;
				stall_run <= gap_len();
			end
		end
	end

	// watchdog on cycles with no transaction on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (evt_valid && !evt_stall) ||
					(cfg_valid && cfg_ready))
				idle_run <= 0;
			else if (idle_run >= IDLE_LIMIT) begin
				$display("tb_av_sync_frame_release_queue: done, errors");
				$finish;
			end else
				idle_run <= idle_run + 1;
		end
	end

	initial begin
		logic [31:0] lim_late;
		logic [31:0] lim_early;
		media_us = longint'($urandom);

		// directed table, reset limits of 40000 and 5000 in force
		// stopped: tick, push and pause do nothing
		plan.push_back(step_row(CMD_TICK, 0, 0, 0, ROW_QUIET, 0, ACT_RENDER));
		plan.push_back(step_row(CMD_PUSH, 0, 16'hFFFF, 0, ROW_QUIET, 0, ACT_RENDER));
		plan.push_back(step_row(CMD_PAUSE, 0, 0, 0, ROW_QUIET, 0, ACT_RENDER));
		plan.push_back(step_row(CMD_START, 0, 0, 0, ROW_QUIET, 0, ACT_RENDER));
		// timestamp extremes, delay clamps at both ends
		plan.push_back(step_row(CMD_PUSH, PTS_MAX, 16'hFFFF, 0, ROW_QUIET, 0, ACT_RENDER));
		plan.push_back(step_row(CMD_TICK, 0, 0, PTS_MIN, ROW_QUIET, 0, ACT_RENDER));
		plan.push_back(step_row(CMD_PUSH, PTS_MIN, 16'h0000, 0, ROW_QUIET, 0, ACT_RENDER));
		plan.push_back(step_row(CMD_TICK, 0, 0, PTS_MAX, ROW_EVENT, 16'hFFFF, ACT_RENDER));
		plan.push_back(step_row(CMD_TICK, 0, 0, PTS_MAX, ROW_EVENT, 16'h0000, ACT_LATE));
		// pushes go on while paused; the ninth one overflows
		plan.push_back(step_row(CMD_PAUSE, 0, 0, 0, ROW_QUIET, 0, ACT_RENDER));
		for (int k = 1; k <= DEPTH; k++)
			plan.push_back(step_row(CMD_PUSH, 64'(1000 * k), 16'(k), 0, ROW_MODEL, 0,
				ACT_RENDER));
		plan.push_back(step_row(CMD_PUSH, 9000, 16'd9, 0, ROW_EVENT, 16'd1, ACT_OVERFLOW));
		plan.push_back(step_row(CMD_TICK, 0, 0, 0, ROW_QUIET, 0, ACT_RENDER));
		plan.push_back(step_row(CMD_RESUME, 0, 0, 0, ROW_QUIET, 0, ACT_RENDER));
		// release, late, exactly at the late edge, exactly at the early edge
		plan.push_back(step_row(CMD_TICK, 0, 0, 0, ROW_MODEL, 0, ACT_RENDER));
		plan.push_back(step_row(CMD_TICK, 0, 0, 48001, ROW_MODEL, 0, ACT_RENDER));
		plan.push_back(step_row(CMD_TICK, 0, 0, 44000, ROW_MODEL, 0, ACT_RENDER));
		plan.push_back(step_row(CMD_TICK, 0, 0, 0, ROW_MODEL, 0, ACT_RENDER));
		plan.push_back(step_row(CMD_FLUSH, 0, 0, 0, ROW_QUIET, 0, ACT_RENDER));
		plan.push_back(step_row(CMD_STOP, 0, 0, 0, ROW_QUIET, 0, ACT_RENDER));
		plan.push_back(step_row(CMD_UNUSED, -1, 16'hFFFF, -1, ROW_QUIET, 0, ACT_RENDER));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			send_cmd(plan[i].cmd, plan[i].kind, plan[i].ev);
			idle_cmd(gap_len());
		end

		// random phases, each under a pair of limits picked by the phase number
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_releases();
			case (ph % 7)
				0: begin
					lim_late = LATE_LIMIT_RESET;
					lim_early = EARLY_WINDOW_RESET;
				end
				1: begin
					lim_late = 32'd0;
					lim_early = 32'd0;
				end
				2: begin
					lim_late = 32'hFFFF_FFFF;
					lim_early = 32'hFFFF_FFFF;
				end
				3: begin
					lim_late = 32'd0;
					lim_early = 32'hFFFF_FFFF;
				end
				4: begin
					lim_late = 32'hFFFF_FFFF;
					lim_early = 32'd0;
				end
				5: begin
					lim_late = $urandom;
					lim_early = $urandom;
				end
				default: begin
					lim_late = $urandom_range(0, 100000);
					lim_early = $urandom_range(0, 20000);
				end
			endcase
			// a write to an unused index must leave both limits alone
			if (ph == 0)
				write_reg(REG_UNUSED, $urandom);
			write_reg(REG_LATE_LIMIT, lim_late);
			write_reg(REG_EARLY_WINDOW, lim_early);
			cfg_valid <= 1'b0;
			steady = (ph % 4 == 2);
			repeat (PHASE_ITEMS) begin
				send_cmd(make_cmd(), ROW_MODEL, '0);
				idle_cmd(gap_len());
			end
		end

		drain_releases();
		fault_count += pending_releases.size();
		if (fault_count == 0)
			$display("tb_av_sync_frame_release_queue: done, clean");
		else
			$display("tb_av_sync_frame_release_queue: done, errors");
		$finish;
	end

endmodule
